@@ design/source_lexer_tokenizer_assert.svh @@
// Assertion helpers shared by the lexer modules.
// Each use expects clk and arst_n in scope.
`ifndef SOURCE_LEXER_TOKENIZER_ASSERT_SVH
`define SOURCE_LEXER_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/slt_pkg.sv @@
package slt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_BADID,
		MODE_IDENT,
		MODE_OPER
	} scan_mode_t;

	typedef enum logic [3:0] {
		CLS_INT         = 4'd0,
		CLS_FLOAT       = 4'd1,
		CLS_IDENT       = 4'd2,
		CLS_KEYWORD     = 4'd3,
		CLS_DELIM       = 4'd4,
		CLS_OPER        = 4'd5,
		CLS_COMMENT     = 4'd6,
		CLS_BAD_IDENT   = 4'd7,
		CLS_MULTI_POINT = 4'd8,
		CLS_BAD_CHAR    = 4'd9
	} token_class_t;

	localparam int KEYWORD_COUNT = 8;
	localparam int PREFIX_BYTES  = 5;
	localparam int OUTQ_DEPTH    = 4;
	localparam int OUTQ_AW       = 2;

	typedef logic [8*PREFIX_BYTES-1:0] prefix_t;

	// Keywords packed big-endian, first character in the high byte.
	localparam prefix_t KW_TEXT [KEYWORD_COUNT] = '{
		40'h0000006966,     // if
		40'h00656C7365,     // else
		40'h0000666F72,     // for
		40'h7768696C65,     // while
		40'h000000646F,     // do
		40'h0000696E74,     // int
		40'h0072656164,     // read
		40'h7772697465      // write
	};
	localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
		3'd2, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5
	};

	typedef struct packed {
		token_class_t token_class;
		logic [2:0]   keyword_number;
		logic [31:0]  start_position;
		logic [15:0]  token_length;
		logic [31:0]  line_number;
		logic         pad_leading_zero;
		logic         pad_trailing_zero;
		logic         last_of_run;
	} token_t;

	// Results of one accepted item, in order, bound for the output queue.
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_delim(logic [7:0] c);
		return (c == "(") || (c == ")") || (c == "{") || (c == "}") ||
			(c == ";") || (c == ",");
	endfunction

	function automatic logic is_op(logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
			(c == "=") || (c == "!") || (c == ">") || (c == "<");
	endfunction

endpackage

@@ design/slt_if.sv @@
interface slt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_marker;

	modport source (output valid, output char_byte, output end_marker, input ready);
	modport sink (input valid, input char_byte, input end_marker, output ready);
endinterface

interface slt_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_class;
	logic [2:0]  keyword_number;
	logic [31:0] start_position;
	logic [15:0] token_length;
	logic [31:0] line_number;
	logic        pad_leading_zero;
	logic        pad_trailing_zero;
	logic        last_of_run;

	modport source (output valid, output token_class, output keyword_number,
		output start_position, output token_length, output line_number,
		output pad_leading_zero, output pad_trailing_zero, output last_of_run,
		input ready);
	modport sink (input valid, input token_class, input keyword_number,
		input start_position, input token_length, input line_number,
		input pad_leading_zero, input pad_trailing_zero, input last_of_run,
		output ready);
endinterface

@@ design/slt_step.sv @@
module slt_step #(
	parameter int LENGTH_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     char_byte,
	input  logic           end_marker,
	output slt_pkg::push_t push
);
	import slt_pkg::*;
	`include "source_lexer_tokenizer_assert.svh"

	scan_mode_t             mode_q, mode_d;
	logic [1:0]             point_count_q, point_count_d;
	logic                   began_point_q, began_point_d;
	logic                   prev_point_q, prev_point_d;
	prefix_t                prefix_q, prefix_d;
	logic [LENGTH_BITS-1:0] cur_len_q, cur_len_d, grown_len;
	logic [31:0]            tok_start_q, tok_start_d;
	logic [31:0]            char_pos_q, char_pos_d;
	logic [31:0]            line_q, line_d;
	logic [7:0]             held_op_q, held_op_d;

	logic [31:0] len_ext;
	logic [15:0] rep_len;
	token_t      fl_tok, a_tok, b_tok, base_tok;
	logic        fl_valid, kw_hit, a_valid, b_valid, do_idle;
	logic [2:0]  kw_idx;

	always_comb begin
		len_ext   = 32'(cur_len_q);
		rep_len   = (len_ext > 32'h0000FFFF) ? 16'hFFFF : len_ext[15:0];
		grown_len = (cur_len_q == '1) ? cur_len_q
			: cur_len_q + {{(LENGTH_BITS-1){1'b0}}, 1'b1};

		base_tok = '{token_class: CLS_INT, keyword_number: 3'd0,
			start_position: tok_start_q, token_length: rep_len, line_number: line_q,
			pad_leading_zero: 1'b0, pad_trailing_zero: 1'b0, last_of_run: 1'b0};

		// Keyword lookup against the stored word prefix.
		kw_hit = 1'b0;
		kw_idx = 3'd0;
		for (int i = 0; i < KEYWORD_COUNT; i++) begin
			if (!kw_hit && (32'(KW_LEN[i]) == len_ext) && (KW_TEXT[i] == prefix_q)) begin
				kw_hit = 1'b1;
				kw_idx = 3'(i);
			end
		end

		// Token closed by the pending state.
		fl_tok   = base_tok;
		fl_valid = 1'b1;
		case (mode_q)
			MODE_NUM: begin
				if (point_count_q == 2'd0) begin
					fl_tok.token_class = CLS_INT;
				end else if (point_count_q == 2'd1) begin
					fl_tok.token_class = CLS_FLOAT;
				end else begin
					fl_tok.token_class = CLS_MULTI_POINT;
				end
				if (point_count_q < 2'd2) begin
					fl_tok.pad_leading_zero  = began_point_q;
					fl_tok.pad_trailing_zero = prev_point_q;
				end
			end
			MODE_BADID: begin
				fl_tok.token_class = CLS_BAD_IDENT;
			end
			MODE_IDENT: begin
				fl_tok.token_class    = kw_hit ? CLS_KEYWORD : CLS_IDENT;
				fl_tok.keyword_number = kw_idx;
			end
			MODE_OPER: begin
				fl_tok.token_class  = CLS_OPER;
				fl_tok.token_length = 16'd1;
			end
			default: begin
				fl_valid = 1'b0;
			end
		endcase

		mode_d        = mode_q;
		point_count_d = point_count_q;
		began_point_d = began_point_q;
		prev_point_d  = prev_point_q;
		prefix_d      = prefix_q;
		cur_len_d     = cur_len_q;
		tok_start_d   = tok_start_q;
		char_pos_d    = char_pos_q;
		line_d        = line_q;
		held_op_d     = held_op_q;
		a_tok         = fl_tok;
		a_valid       = 1'b0;
		b_tok         = base_tok;
		b_valid       = 1'b0;
		do_idle       = 1'b0;

		if (accept) begin
			if (end_marker) begin
				a_valid = fl_valid;
				mode_d  = MODE_IDLE;
			end else begin
				char_pos_d = char_pos_q + 32'd1;
				case (mode_q)
					MODE_NUM: begin
						if (is_digit(char_byte)) begin
							cur_len_d    = grown_len;
							prev_point_d = 1'b0;
						end else if (char_byte == ".") begin
							cur_len_d    = grown_len;
							prev_point_d = 1'b1;
							if (point_count_q != 2'd2) begin
								point_count_d = point_count_q + 2'd1;
							end
						end else if (is_letter(char_byte)) begin
							cur_len_d = grown_len;
							mode_d    = MODE_BADID;
						end else begin
							do_idle = 1'b1;
						end
					end
					MODE_BADID: begin
						if (is_delim(char_byte) || is_op(char_byte) ||
							(char_byte == " ") || (char_byte == 8'h0A)) begin
							do_idle = 1'b1;
						end else begin
							cur_len_d = grown_len;
						end
					end
					MODE_IDENT: begin
						if (is_letter(char_byte) || is_digit(char_byte)) begin
							if (len_ext < 32'(PREFIX_BYTES)) begin
								prefix_d = {prefix_q[8*PREFIX_BYTES-9:0], char_byte};
							end
							cur_len_d = grown_len;
						end else begin
							do_idle = 1'b1;
						end
					end
					MODE_OPER: begin
						a_tok.token_length = 16'd2;
						if ((char_byte == "=") || ((char_byte == held_op_q) &&
							((char_byte == "+") || (char_byte == "-") ||
							(char_byte == "/")))) begin
							a_valid = 1'b1;
							mode_d  = MODE_IDLE;
						end else if (((held_op_q == "/") && (char_byte == "*")) ||
							((held_op_q == "*") && (char_byte == "/"))) begin
							a_tok.token_class = CLS_COMMENT;
							a_valid           = 1'b1;
							mode_d            = MODE_IDLE;
						end else begin
							a_tok   = fl_tok;
							do_idle = 1'b1;
						end
					end
					default: begin
						do_idle = 1'b1;
					end
				endcase

				// Close the pending token, then scan this byte from idle.
				if (do_idle) begin
					a_valid     = fl_valid;
					mode_d      = MODE_IDLE;
					tok_start_d = char_pos_q;
					cur_len_d   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
					b_tok.start_position = char_pos_q;
					b_tok.token_length   = 16'd1;
					if (is_digit(char_byte) || (char_byte == ".")) begin
						mode_d        = MODE_NUM;
						point_count_d = {1'b0, char_byte == "."};
						began_point_d = (char_byte == ".");
						prev_point_d  = (char_byte == ".");
					end else if (is_delim(char_byte)) begin
						b_tok.token_class = CLS_DELIM;
						b_valid           = 1'b1;
					end else if (is_op(char_byte)) begin
						mode_d    = MODE_OPER;
						held_op_d = char_byte;
					end else if (is_letter(char_byte)) begin
						mode_d   = MODE_IDENT;
						prefix_d = {{(8*PREFIX_BYTES-8){1'b0}}, char_byte};
					end else if (char_byte == " ") begin
						b_valid = 1'b0;
					end else if (char_byte == 8'h0A) begin
						if (line_q != '1) begin
							line_d = line_q + 32'd1;
						end
					end else begin
						b_tok.token_class = CLS_BAD_CHAR;
						b_valid           = 1'b1;
					end
				end
			end
		end

		// Pack results in order and flag the last one.
		push.first  = a_valid ? a_tok : b_tok;
		push.second = b_tok;
		push.second.last_of_run = 1'b1;
		if (a_valid) begin
			push.count             = b_valid ? 2'd2 : 2'd1;
			push.first.last_of_run = !b_valid;
		end else begin
			push.count             = b_valid ? 2'd1 : 2'd0;
			push.first.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			point_count_q <= 2'd0;
			began_point_q <= 1'b0;
			prev_point_q  <= 1'b0;
			prefix_q      <= '0;
			cur_len_q     <= '0;
			tok_start_q   <= 32'd0;
			char_pos_q    <= 32'd0;
			line_q        <= 32'd1;
			held_op_q     <= 8'd0;
		end else begin
			mode_q        <= mode_d;
			point_count_q <= point_count_d;
			began_point_q <= began_point_d;
			prev_point_q  <= prev_point_d;
			prefix_q      <= prefix_d;
			cur_len_q     <= cur_len_d;
			tok_start_q   <= tok_start_d;
			char_pos_q    <= char_pos_d;
			line_q        <= line_d;
			held_op_q     <= held_op_d;
		end
	end

	`SLT_ASSERT_NOW(a_line_nonzero, 1'b1, line_q != 32'd0, "line counter reached zero")
	`SLT_ASSERT_NOW(a_no_push_idle, !accept, push.count == 2'd0, "results without an item")
	`SLT_ASSERT_NOW(a_pair_last, push.count == 2'd2,
		!push.first.last_of_run && push.second.last_of_run, "bad last flag on a pair")

endmodule

@@ design/slt_outq.sv @@
module slt_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  slt_pkg::push_t  push,
	input  logic            pop,
	output logic            room,
	output logic            head_valid,
	output slt_pkg::token_t head
);
	import slt_pkg::*;
	`include "source_lexer_tokenizer_assert.svh"

	token_t             entry [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_q, rd_q;
	logic [OUTQ_AW:0]   count_q;

	assign room       = count_q <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = entry[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry[OUTQ_AW'(wr_q + 1'b1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= OUTQ_AW'(wr_q + push.count);
			rd_q    <= OUTQ_AW'(rd_q + pop);
			count_q <= (OUTQ_AW+1)'(count_q + push.count - pop);
		end
	end

	`SLT_ASSERT_NOW(a_no_overflow, push.count != 2'd0,
		(4'(count_q) + 4'(push.count)) <= 4'(OUTQ_DEPTH), "result queue overflow")
	`SLT_ASSERT_NEXT(a_hold_count, (push.count == 2'd0) && !pop, $stable(count_q),
		"queue count moved while idle")
	`SLT_ASSERT_NOW(a_pop_has_head, pop, head_valid, "pop from an empty queue")

endmodule

@@ design/source_lexer_tokenizer.sv @@
// Character lexer for a small C subset. Takes one source byte (or an end
// marker) per item on chars and returns tokens on tokens, each as class,
// keyword index, start offset, length, line number and number pad flags;
// last_of_run marks the final token caused by one input item. A new byte is
// accepted every cycle while chars.ready is high: the scanner state and the
// classification of the byte are one short step of logic, and the one or two
// tokens a byte completes are written straight into a four-entry result
// queue, which registers them before they appear on the output. chars.ready
// drops only while the queue has fewer than two free entries, so a byte that
// ends two tokens at once always finds room for both; a steady stream whose
// consumer always takes tokens runs at one byte per cycle. No clearing pass
// after reset.
module source_lexer_tokenizer #(
	parameter int LENGTH_BITS = 16
) (
	input logic               clk,
	input logic               arst_n,
	slt_char_if.sink          chars,
	slt_token_if.source       tokens
);
	import slt_pkg::*;

	logic   accept, room, head_valid, pop;
	push_t  push;
	token_t head;

	// Take a byte whenever the queue can hold the worst case of two tokens.
	assign chars.ready = room;
	assign accept      = chars.valid && room;
	assign pop         = head_valid && tokens.ready;

	slt_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_byte  (chars.char_byte),
		.end_marker (chars.end_marker),
		.push       (push)
	);

	slt_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room       (room),
		.head_valid (head_valid),
		.head       (head)
	);

	// Drive the token channel from the queue head.
	assign tokens.valid             = head_valid;
	assign tokens.token_class       = head.token_class;
	assign tokens.keyword_number    = head.keyword_number;
	assign tokens.start_position    = head.start_position;
	assign tokens.token_length      = head.token_length;
	assign tokens.line_number       = head.line_number;
	assign tokens.pad_leading_zero  = head.pad_leading_zero;
	assign tokens.pad_trailing_zero = head.pad_trailing_zero;
	assign tokens.last_of_run       = head.last_of_run;

endmodule
